// File: design/mcwa_pkg.sv
package mcwa_pkg;

  localparam int unsigned SAMPLE_W = 20;
  localparam int unsigned CH_W     = 2;
  localparam int unsigned USED_W   = 5;
  localparam int unsigned CHANNELS = 3;

  localparam logic [CH_W-1:0] CH_WIND_SPEED = 2'd0;
  localparam logic [CH_W-1:0] CH_WIND_ANGLE = 2'd1;
  localparam logic [CH_W-1:0] CH_HEADING    = 2'd2;
  localparam logic [CH_W-1:0] CH_UNUSED     = 2'd3;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 20'sh80000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 20'sh7FFFF;

endpackage

// File: design/mcwa_ram.sv
module mcwa_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/multi_channel_window_averager.sv
// channel | signals                                         | direction
// in      | in_valid_i, in_stall_o, channel_i,              | into block
//         | sample_value_i, to_left_i                       |
// out     | out_valid_o, out_stall_i, channel_echo_o,       | out of block
//         | average_value_o, entries_used_o                 |
//
// a new item is taken only once the last one is through: the store read, then the update and
// write back, then one quotient bit per cycle in the serial divider
// reset clears fill counts, ring positions and sums; the sample store is not swept, entries
// beyond a channel's fill count are never used
// a result waiting on out_stall_i holds the output register; the next transfer in is still taken
// a channel code of three is taken and dropped without a result
module multi_channel_window_averager
  import mcwa_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [CH_W-1:0]            channel_i,
  input  logic signed [SAMPLE_W-1:0] sample_value_i,
  input  logic                       to_left_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [CH_W-1:0]            channel_echo_o,
  output logic signed [SAMPLE_W-1:0] average_value_o,
  output logic [USED_W-1:0]          entries_used_o
);

  localparam int unsigned POS_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W  = SAMPLE_W + CNT_W;
  localparam int unsigned MEM_D  = CHANNELS * WINDOW_DEPTH;
  localparam int unsigned ADDR_W = $clog2(MEM_D);
  localparam int unsigned ITER_W = $clog2(SUM_W + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_DIV,
    S_DONE
  } state_e;

  state_e                     state_q;
  logic [POS_W-1:0]           pos_q [CHANNELS];
  logic [CNT_W-1:0]           cnt_q [CHANNELS];
  logic signed [SUM_W-1:0]    sum_q [CHANNELS];
  logic [CH_W-1:0]            ch_q;
  logic signed [SAMPLE_W-1:0] smp_q;
  logic [ADDR_W-1:0]          addr_q;
  logic                       neg_q;
  logic [CNT_W-1:0]           div_q;
  logic [CNT_W-1:0]           rem_q;
  logic [SUM_W-1:0]           quo_q;
  logic [ITER_W-1:0]          iter_q;
  logic                       out_valid_q;
  logic [CH_W-1:0]            out_ch_q;
  logic [SAMPLE_W-1:0]        out_avg_q;
  logic [USED_W-1:0]          out_used_q;

  logic                       in_xfer;
  logic [CH_W-1:0]            ch_idx;
  logic [ADDR_W-1:0]          raddr;
  logic signed [SAMPLE_W-1:0] smp_in;
  logic [SAMPLE_W-1:0]        rdata;
  logic                       full;
  logic signed [SUM_W-1:0]    old_ext;
  logic signed [SUM_W-1:0]    new_ext;
  logic signed [SUM_W-1:0]    sum_d;
  logic [SUM_W-1:0]           mag_d;
  logic [CNT_W-1:0]           cnt_d;
  logic [POS_W-1:0]           pos_d;
  logic [CNT_W:0]             trial;
  logic                       qbit;
  logic [CNT_W-1:0]           rem_d;
  logic [SUM_W-1:0]           mean;
  logic                       mem_we;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign ch_idx     = (channel_i == CH_UNUSED) ? CH_WIND_SPEED : channel_i;
  assign raddr      = ADDR_W'(ch_idx * WINDOW_DEPTH) + ADDR_W'(pos_q[ch_idx]);

  always_comb begin
    smp_in = sample_value_i;
    if (channel_i == CH_WIND_ANGLE && to_left_i) begin
      smp_in = (sample_value_i == SAMPLE_MIN) ? SAMPLE_MAX : -sample_value_i;
    end
  end

  // read, modify and write back of the oldest entry
  assign full    = (cnt_q[ch_q] == CNT_W'(WINDOW_DEPTH));
  assign old_ext = full ? {{CNT_W{rdata[SAMPLE_W-1]}}, rdata} : '0;
  assign new_ext = {{CNT_W{smp_q[SAMPLE_W-1]}}, smp_q};
  assign sum_d   = sum_q[ch_q] - old_ext + new_ext;
  assign mag_d   = sum_d[SUM_W-1] ? SUM_W'(-sum_d) : SUM_W'(sum_d);
  assign cnt_d   = full ? cnt_q[ch_q] : cnt_q[ch_q] + 1'b1;
  assign pos_d   = (pos_q[ch_q] == POS_W'(WINDOW_DEPTH - 1)) ? '0 : pos_q[ch_q] + 1'b1;
  assign mem_we  = (state_q == S_UPDATE);

  // restoring divider, one quotient bit per cycle
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign qbit  = (trial >= {1'b0, div_q});
  assign rem_d = qbit ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];
  assign mean  = neg_q ? SUM_W'(-quo_q) : quo_q;

  mcwa_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MEM_D)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (addr_q),
    .wdata_i (smp_q),
    .re_i    (in_xfer),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      ch_q        <= '0;
      smp_q       <= '0;
      addr_q      <= '0;
      neg_q       <= 1'b0;
      div_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      iter_q      <= '0;
      out_ch_q    <= '0;
      out_avg_q   <= '0;
      out_used_q  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        pos_q[i] <= '0;
        cnt_q[i] <= '0;
        sum_q[i] <= '0;
      end
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer && channel_i != CH_UNUSED) begin
            ch_q    <= channel_i;
            smp_q   <= smp_in;
            addr_q  <= raddr;
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          sum_q[ch_q] <= sum_d;
          cnt_q[ch_q] <= cnt_d;
          pos_q[ch_q] <= pos_d;
          neg_q       <= sum_d[SUM_W-1];
          div_q       <= cnt_d;
          rem_q       <= '0;
          quo_q       <= mag_d;
          iter_q      <= ITER_W'(SUM_W);
          state_q     <= S_DIV;
        end
        S_DIV: begin
          rem_q  <= rem_d;
          quo_q  <= {quo_q[SUM_W-2:0], qbit};
          iter_q <= iter_q - 1'b1;
          if (iter_q == ITER_W'(1)) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_ch_q    <= ch_q;
            out_avg_q   <= mean[SAMPLE_W-1:0];
            out_used_q  <= USED_W'(div_q);
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign channel_echo_o  = out_ch_q;
  assign average_value_o = out_avg_q;
  assign entries_used_o  = out_used_q;

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPDATE |-> cnt_q[ch_q] <= CNT_W'(WINDOW_DEPTH)
                            && pos_q[ch_q] <= POS_W'(WINDOW_DEPTH - 1))
    else $error("fill count or ring position out of range");

  a_write_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> $past(in_xfer))
    else $error("store written without a preceding read");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the final step");

  a_div_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> iter_q != '0 && div_q != '0)
    else $error("divider running with no steps left or a zero divisor");

endmodule

// File: dv/tb_multi_channel_window_averager.sv
`timescale 1ns / 1ps

module tb_multi_channel_window_averager;
  import mcwa_pkg::*;

  localparam int unsigned WINDOW_DEPTH = 16;
  localparam int unsigned PHASE_ITEMS  = 330;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [CH_W-1:0]            ch;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       left;
  } reading_t;

  typedef struct packed {
    logic [CH_W-1:0]            ch;
    logic signed [SAMPLE_W-1:0] avg;
    logic [USED_W-1:0]          used;
  } average_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [CH_W-1:0]            channel_i = '0;
  logic signed [SAMPLE_W-1:0] sample_value_i = '0;
  logic                       to_left_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [CH_W-1:0]            channel_echo_o;
  logic signed [SAMPLE_W-1:0] average_value_o;
  logic [USED_W-1:0]          entries_used_o;

  reading_t pending_readings[$];
  average_t expected_averages[$];

  logic signed [SAMPLE_W-1:0] win_sample [CHANNELS][WINDOW_DEPTH];
  bit                         win_full   [CHANNELS][WINDOW_DEPTH];
  int unsigned                win_pos    [CHANNELS];
  longint                     win_sum    [CHANNELS];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        rx_hold = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned mismatches = 0;

  multi_channel_window_averager #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .channel_i      (channel_i),
    .sample_value_i (sample_value_i),
    .to_left_i      (to_left_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .channel_echo_o (channel_echo_o),
    .average_value_o(average_value_o),
    .entries_used_o (entries_used_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void predict_average(reading_t r);
    int unsigned slot;
    int          used;
    logic signed [SAMPLE_W-1:0] val;
    average_t    avg_item;
    if (r.ch == CH_UNUSED) return;
    val = r.sample;
    if (r.ch == CH_WIND_ANGLE && r.left) begin
      val = (r.sample == SAMPLE_MIN) ? SAMPLE_MAX : -r.sample;
    end
    slot = win_pos[r.ch];
    if (win_full[r.ch][slot]) win_sum[r.ch] -= win_sample[r.ch][slot];
    win_sample[r.ch][slot] = val;
    win_full[r.ch][slot] = 1'b1;
    win_sum[r.ch] += val;
    win_pos[r.ch] = (slot + 1) % WINDOW_DEPTH;
    used = 0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      if (win_full[r.ch][i]) used++;
    end
    avg_item.ch   = r.ch;
    avg_item.avg  = SAMPLE_W'(win_sum[r.ch] / longint'(used));
    avg_item.used = USED_W'(used);
    expected_averages.push_back(avg_item);
  endfunction

  task automatic queue_reading(logic [CH_W-1:0] ch, logic signed [SAMPLE_W-1:0] s,
                               logic left);
    reading_t r;
    r.ch = ch;
    r.sample = s;
    r.left = left;
    pending_readings.push_back(r);
  endtask

  function automatic reading_t random_reading();
    reading_t r;
    r.ch = ($urandom_range(19) == 0) ? CH_UNUSED : CH_W'($urandom_range(2));
    case ($urandom_range(9))
      0:       r.sample = SAMPLE_MIN;
      1:       r.sample = SAMPLE_MAX;
      2:       r.sample = SAMPLE_W'(-1);
      3, 4:    r.sample = SAMPLE_W'(int'($urandom_range(2047)) - 1024);
      default: r.sample = SAMPLE_W'($urandom);
    endcase
    r.left = 1'($urandom_range(1));
    return r;
  endfunction

  task automatic drain();
    do @(posedge clk_i);
    while (pending_readings.size() != 0 || in_valid_i || expected_averages.size() != 0);
  endtask

  // sender: transfer on valid and not stall, otherwise hold the payload
  always @(posedge clk_i) begin
    reading_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        nxt.ch = channel_i;
        nxt.sample = sample_value_i;
        nxt.left = to_left_i;
        predict_average(nxt);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_readings.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = pending_readings.pop_front();
          in_valid_i     <= 1'b1;
          channel_i      <= nxt.ch;
          sample_value_i <= nxt.sample;
          to_left_i      <= nxt.left;
        end else begin
          in_valid_i     <= 1'b0;
          channel_i      <= CH_W'($urandom);
          sample_value_i <= SAMPLE_W'($urandom);
          to_left_i      <= 1'($urandom);
        end
      end
    end
  end

  // receiver: check each transfer out against the oldest prediction
  always @(posedge clk_i) begin
    average_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_averages.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: ch %0d avg %0d used %0d",
                     channel_echo_o, average_value_o, entries_used_o);
          end
        end else begin
          want = expected_averages.pop_front();
          if (channel_echo_o !== want.ch || average_value_o !== want.avg ||
              entries_used_o !== want.used) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected ch %0d avg %0d used %0d, got ch %0d avg %0d used %0d",
                       want.ch, want.avg, want.used,
                       channel_echo_o, average_value_o, entries_used_o);
            end
          end
        end
      end
      out_stall_i <= rx_hold || ($urandom_range(99) < rx_idle_pct);
    end
  end

  // long receiver hold-off so the block backs up onto its input
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    for (int c = 0; c < CHANNELS; c++) begin
      win_pos[c] = 0;
      win_sum[c] = 0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_sample[c][i] = '0;
        win_full[c][i] = 1'b0;
      end
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    queue_reading(CH_WIND_SPEED, SAMPLE_W'(0), 1'b0);
    queue_reading(CH_WIND_SPEED, SAMPLE_MAX, 1'b0);
    queue_reading(CH_WIND_SPEED, SAMPLE_MIN, 1'b0);
    queue_reading(CH_WIND_SPEED, SAMPLE_W'(-1), 1'b0);
    queue_reading(CH_WIND_SPEED, SAMPLE_W'(256), 1'b1);
    queue_reading(CH_WIND_ANGLE, SAMPLE_MIN, 1'b1);
    queue_reading(CH_WIND_ANGLE, SAMPLE_MAX, 1'b1);
    queue_reading(CH_WIND_ANGLE, SAMPLE_MIN, 1'b0);
    queue_reading(CH_WIND_ANGLE, SAMPLE_W'(-1), 1'b1);
    queue_reading(CH_WIND_ANGLE, SAMPLE_W'(1000), 1'b0);
    queue_reading(CH_HEADING, SAMPLE_W'(-3), 1'b0);
    queue_reading(CH_HEADING, SAMPLE_W'(-2), 1'b0);
    queue_reading(CH_HEADING, SAMPLE_W'(5), 1'b1);
    queue_reading(CH_HEADING, SAMPLE_MAX, 1'b0);
    queue_reading(CH_HEADING, SAMPLE_MAX, 1'b0);
    queue_reading(CH_UNUSED, SAMPLE_MAX, 1'b0);
    queue_reading(CH_UNUSED, SAMPLE_MIN, 1'b1);
    queue_reading(CH_WIND_SPEED, SAMPLE_W'(7), 1'b0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 21; rx_idle_pct = 49; end
        1: begin tx_idle_pct = 49; rx_idle_pct = 21; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) pending_readings.push_back(random_reading());
      if (phase == 2) hold_req = 1'b1;
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    mismatches += expected_averages.size();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
